// File: rtl/assert_macros.svh
// Concurrent assertion helpers, clocked on clk and disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/nat_pkg.sv
`timescale 1ns / 1ps

package nat_pkg;

  localparam int IP_W      = 64;
  localparam int MAC_W     = 48;
  localparam int OUT_IDX_W = 4;
  localparam int ENTRY_W   = 2 * IP_W + MAC_W;

  localparam logic ACT_LOOKUP = 1'b0;
  localparam logic ACT_ADD    = 1'b1;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  typedef struct packed {
    logic             action;
    logic             match_ip;
    logic             match_mac;
    logic [IP_W-1:0]  ip_upper;
    logic [IP_W-1:0]  ip_lower;
    logic [MAC_W-1:0] mac_in;
  } nat_req_t;

  typedef struct packed {
    logic                 hit;
    logic [OUT_IDX_W-1:0] entry_index;
    logic [IP_W-1:0]      entry_ip_upper;
    logic [IP_W-1:0]      entry_ip_lower;
    logic [MAC_W-1:0]     entry_mac;
    logic                 status;
  } nat_rsp_t;

endpackage

// File: rtl/nat_chan_if.sv
`timescale 1ns / 1ps

interface nat_chan_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);

endinterface

// File: rtl/nat_ram.sv
`timescale 1ns / 1ps

module nat_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/neighbor_address_table_unit.sv
`timescale 1ns / 1ps
// Neighbor address table: IPv6 to MAC pairs held in one single-port-read memory, filled in
// order of arrival and never evicted. A lookup request returns the first entry that matches
// on IP, MAC, both or neither; an add request updates the MAC of a matching IP or appends a
// new pair, and is dropped with status full when no entry has its IP and the table holds
// TABLE_ENTRIES pairs. Requests are handled one at a time: each is accepted in idle,
// scanned from entry 0 until the first match or the last stored entry, then finished with
// its write-back, if any, and its response; the scan reads one entry per cycle from the
// memory read port. The response sits in an output register, and the unit waits before
// its write-back cycle only while an earlier response is still not taken.
module neighbor_address_table_unit #(
  parameter int TABLE_ENTRIES = 16
) (
  input logic       clk,
  input logic       rst_n,
  nat_chan_if.sink   in_req,
  nat_chan_if.source out_rsp
);

  import nat_pkg::*;

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_FINISH = 3'b100
  } state_t;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [IDX_W-1:0]   cmp_ptr_r, cmp_ptr_nxt;
  nat_req_t           req_r, req_nxt;
  nat_rsp_t           res_r, res_nxt;
  logic               wr_pend_r, wr_pend_nxt;
  logic [IDX_W-1:0]   wr_addr_r, wr_addr_nxt;
  logic               cnt_inc_r, cnt_inc_nxt;
  logic               out_valid_r, out_valid_nxt;
  nat_rsp_t           out_payload_r, out_payload_nxt;

  logic               accept;
  logic               out_free;
  logic               use_ip;
  logic               use_mac;
  logic               match;
  logic               last;
  logic               scan_done;
  logic               full;
  logic               ram_we;
  logic               ram_re;
  logic [IDX_W-1:0]   ram_raddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;
  logic [IP_W-1:0]    rd_ip_upper;
  logic [IP_W-1:0]    rd_ip_lower;
  logic [MAC_W-1:0]   rd_mac;

  nat_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_addr_r),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_req.ready    = (state_r == ST_IDLE);
  assign out_rsp.valid   = out_valid_r;
  assign out_rsp.payload = out_payload_r;

  assign accept   = in_req.valid && in_req.ready;
  assign out_free = !out_valid_r || out_rsp.ready;

  assign {rd_ip_upper, rd_ip_lower, rd_mac} = ram_rdata;
  assign ram_wdata = {req_r.ip_upper, req_r.ip_lower, req_r.mac_in};

  assign use_ip  = (req_r.action == ACT_ADD) || req_r.match_ip;
  assign use_mac = (req_r.action == ACT_LOOKUP) && req_r.match_mac;

  assign match = (count_r != '0)
              && (!use_ip || (rd_ip_upper == req_r.ip_upper && rd_ip_lower == req_r.ip_lower))
              && (!use_mac || rd_mac == req_r.mac_in);
  assign last      = (CNT_W'(cmp_ptr_r) + CNT_W'(1)) >= count_r;
  assign scan_done = (state_r == ST_SCAN) && (match || last);
  assign full      = (count_r == CNT_W'(TABLE_ENTRIES));

  assign ram_re    = accept || ((state_r == ST_SCAN) && !scan_done);
  assign ram_raddr = (state_r == ST_IDLE) ? '0 : cmp_ptr_r + IDX_W'(1);
  assign ram_we    = (state_r == ST_FINISH) && out_free && wr_pend_r;

  always_comb begin
    state_nxt       = state_r;
    cmp_ptr_nxt     = cmp_ptr_r;
    req_nxt         = req_r;
    count_nxt       = count_r;
    out_valid_nxt   = out_valid_r && !out_rsp.ready;
    out_payload_nxt = out_payload_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt   = ST_SCAN;
          cmp_ptr_nxt = '0;
          req_nxt     = in_req.payload;
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          state_nxt = ST_FINISH;
        end else begin
          cmp_ptr_nxt = cmp_ptr_r + IDX_W'(1);
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_nxt       = ST_IDLE;
          out_valid_nxt   = 1'b1;
          out_payload_nxt = res_r;
          if (cnt_inc_r) begin
            count_nxt = count_r + CNT_W'(1);
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    res_nxt     = res_r;
    wr_pend_nxt = wr_pend_r;
    wr_addr_nxt = wr_addr_r;
    cnt_inc_nxt = cnt_inc_r;
    if (scan_done) begin
      res_nxt     = '0;
      wr_pend_nxt = 1'b0;
      wr_addr_nxt = cmp_ptr_r;
      cnt_inc_nxt = 1'b0;
      priority if (match) begin
        res_nxt.hit            = 1'b1;
        res_nxt.entry_index    = OUT_IDX_W'(cmp_ptr_r);
        res_nxt.entry_ip_upper = rd_ip_upper;
        res_nxt.entry_ip_lower = rd_ip_lower;
        res_nxt.entry_mac      = (req_r.action == ACT_ADD) ? req_r.mac_in : rd_mac;
        wr_pend_nxt            = (req_r.action == ACT_ADD);
      end else if (req_r.action == ACT_ADD && !full) begin
        res_nxt.entry_index    = OUT_IDX_W'(count_r);
        res_nxt.entry_ip_upper = req_r.ip_upper;
        res_nxt.entry_ip_lower = req_r.ip_lower;
        res_nxt.entry_mac      = req_r.mac_in;
        wr_pend_nxt            = 1'b1;
        wr_addr_nxt            = IDX_W'(count_r);
        cnt_inc_nxt            = 1'b1;
      end else if (req_r.action == ACT_ADD) begin
        res_nxt.status = STATUS_FULL;
      end else begin
        res_nxt.status = STATUS_OK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      wr_pend_r   <= 1'b0;
      cnt_inc_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      wr_pend_r   <= wr_pend_nxt;
      cnt_inc_r   <= cnt_inc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmp_ptr_r     <= cmp_ptr_nxt;
    req_r         <= req_nxt;
    res_r         <= res_nxt;
    wr_addr_r     <= wr_addr_nxt;
    out_payload_r <= out_payload_nxt;
  end

`include "assert_macros.svh"

  `ASSERT_SAME(a_count_bound, 1'b1, count_r <= CNT_W'(TABLE_ENTRIES), "Entry count above table size")
  `ASSERT_SAME(a_full_drop, out_valid_r && out_payload_r.status == STATUS_FULL, full, "Full drop reported on a table with room")
  `ASSERT_NEXT(a_scan_count, state_r == ST_SCAN, count_r == $past(count_r), "Entry count changed during a scan")
  `ASSERT_SAME(a_write_idle_out, ram_we, state_nxt == ST_IDLE && out_valid_nxt, "Table written without a response")

endmodule
